// ----- rtl/ils_pkg.sv -----
`timescale 1ns / 1ps

package ils_pkg;

    // Operation codes carried in the mode field.
    localparam logic [2:0] MODE_PUSH   = 3'd0;
    localparam logic [2:0] MODE_POP    = 3'd1;
    localparam logic [2:0] MODE_INSERT = 3'd2;
    localparam logic [2:0] MODE_REMOVE = 3'd3;
    localparam logic [2:0] MODE_GET    = 3'd4;
    localparam logic [2:0] MODE_CHANGE = 3'd5;

    // Index width on the broadcast command; covers the deepest supported list.
    localparam int CMD_IDX_BITS = 10;

    typedef struct packed {
        logic [2:0]  mode;
        logic [4:0]  position;
        logic [31:0] item_word;
    } req_t;

    typedef struct packed {
        logic        status;
        logic [31:0] read_word;
        logic [4:0]  count;
    } rsp_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic                    write;
        logic                    shift_up;
        logic                    shift_down;
        logic [CMD_IDX_BITS-1:0] idx;
        logic [CMD_IDX_BITS-1:0] rd_idx;
    } cell_cmd_t;

endpackage

// ----- rtl/indexed_list_store_core.sv -----
`timescale 1ns / 1ps
// Channel | Direction | Handshake             | Word
// req     | in        | req_valid / req_ready | ils_pkg::req_t (mode, position, item_word)
// rsp     | out       | rsp_valid / rsp_ready | ils_pkg::rsp_t (status, read_word, count)
//
// One word is taken per clock while req_ready is high; its response is registered and appears the next cycle.
// Every cell of the chain loads, shifts from a neighbor or holds in the same edge.
// Reset clears the length and the response valid; entry contents are not reset.
// A stalled response holds req_ready low only while the response register is full.

module indexed_list_store_core #(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  ils_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output ils_pkg::rsp_t rsp
);
    import ils_pkg::*;

    localparam int LW = $clog2(DEPTH + 1);
    localparam int CW = (LW > 5) ? LW : 5;
    localparam logic [LW-1:0] FULL_LEN = LW'(DEPTH);

    logic [LW-1:0] length_reg;
    logic [LW-1:0] length_next;
    logic          rsp_valid_reg;
    rsp_t          rsp_reg;

    logic [WORD_BITS-1:0] cell_data [DEPTH];
    logic [WORD_BITS-1:0] cell_rd   [DEPTH];
    logic [WORD_BITS-1:0] rd_or;
    logic [WORD_BITS-1:0] wr_word;

    cell_cmd_t cmd;
    logic      accept;
    logic      err;
    logic      rd_en;
    logic [CW-1:0] pos_ext;
    logic [CW-1:0] len_ext;
    logic          full;
    logic          empty;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign pos_ext   = CW'(req.position);
    assign len_ext   = CW'(length_reg);
    assign full      = (length_reg == FULL_LEN);
    assign empty     = (length_reg == '0);
    assign wr_word   = WORD_BITS'(req.item_word);

    always_comb
    begin
        err         = 1'b0;
        rd_en       = 1'b0;
        length_next = length_reg;
        cmd         = '0;
        cmd.idx     = CMD_IDX_BITS'(req.position);
        cmd.rd_idx  = CMD_IDX_BITS'(req.position);
        unique case (req.mode)
            MODE_PUSH:
            begin
                err         = full;
                cmd.idx     = CMD_IDX_BITS'(length_reg);
                cmd.write   = 1'b1;
                length_next = length_reg + LW'(1);
            end
            MODE_POP:
            begin
                err         = empty;
                rd_en       = 1'b1;
                cmd.rd_idx  = CMD_IDX_BITS'(length_reg - LW'(1));
                length_next = length_reg - LW'(1);
            end
            MODE_INSERT:
            begin
                err          = (pos_ext > len_ext) || full;
                cmd.write    = 1'b1;
                cmd.shift_up = 1'b1;
                length_next  = length_reg + LW'(1);
            end
            MODE_REMOVE:
            begin
                err            = (pos_ext >= len_ext);
                cmd.shift_down = 1'b1;
                length_next    = length_reg - LW'(1);
            end
            MODE_GET:
            begin
                err   = (pos_ext >= len_ext);
                rd_en = 1'b1;
            end
            MODE_CHANGE:
            begin
                err       = (pos_ext >= len_ext);
                cmd.write = 1'b1;
            end
            default:
            begin
                err = 1'b1;
            end
        endcase
        // Nothing in the chain moves unless the word is taken and is legal.
        if (!accept || err)
        begin
            cmd.write      = 1'b0;
            cmd.shift_up   = 1'b0;
            cmd.shift_down = 1'b0;
            length_next    = length_reg;
        end
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        ils_cell #(
            .WORD_BITS (WORD_BITS),
            .CELL_IDX  (i)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .wr_word    (wr_word),
            .left_data  (cell_data[(i == 0) ? 0 : i - 1]),
            .right_data (cell_data[(i == DEPTH - 1) ? i : i + 1]),
            .data       (cell_data[i]),
            .rd_data    (cell_rd[i])
        );
    end

    always_comb
    begin
        rd_or = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rd_or = rd_or | cell_rd[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            length_reg <= length_next;
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg.status    <= err;
            rsp_reg.read_word <= (rd_en && !err) ? 32'(rd_or) : 32'd0;
            rsp_reg.count     <= 5'(length_next);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- rtl/ils_cell.sv -----
`timescale 1ns / 1ps

module ils_cell #(
    parameter int WORD_BITS = 32,
    parameter int CELL_IDX  = 0
) (
    input  logic                  clk,
    input  ils_pkg::cell_cmd_t    cmd,
    input  logic [WORD_BITS-1:0]  wr_word,
    input  logic [WORD_BITS-1:0]  left_data,
    input  logic [WORD_BITS-1:0]  right_data,
    output logic [WORD_BITS-1:0]  data,
    output logic [WORD_BITS-1:0]  rd_data
);
    import ils_pkg::*;

    localparam logic [CMD_IDX_BITS-1:0] MY_IDX = CMD_IDX_BITS'(CELL_IDX);

    logic [WORD_BITS-1:0] data_reg;
    logic [WORD_BITS-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (cmd.write && (cmd.idx == MY_IDX))
        begin
            data_next = wr_word;
        end
        else if (cmd.shift_up && (MY_IDX > cmd.idx))
        begin
            data_next = left_data;
        end
        else if (cmd.shift_down && (MY_IDX >= cmd.idx))
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign rd_data = (cmd.rd_idx == MY_IDX) ? data_reg : '0;

endmodule
